@@ hw/rtl/srsv_pkg.sv @@
// Shared types and constants for the sensor range and stuck-value validator.
// Used by srsv_lane, srsv_merge and sensor_range_stuck_validator; no dependencies.
package srsv_pkg;

   // number of sensor lanes that are built (1 or 2); result slots stay at 2
   localparam int SENSOR_LANES = 2;
   localparam int LANE_SLOTS   = 2;

   localparam int RAW_W   = 16;
   localparam int RUN_W   = 8;
   localparam int COUNT_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [RUN_W-1:0] RUN_MAX = 8'hFF;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SENSOR0      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SENSOR0      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SENSOR1      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SENSOR1      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STUCK_LIMIT      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBSTITUTE_VALUE = 3'd5;

   // register reset values
   localparam logic [RAW_W-1:0] MIN_SENSOR0_RST = 16'd200;
   localparam logic [RAW_W-1:0] MAX_SENSOR0_RST = 16'd3800;
   localparam logic [RAW_W-1:0] MIN_SENSOR1_RST = 16'd100;
   localparam logic [RAW_W-1:0] MAX_SENSOR1_RST = 16'd900;
   localparam logic [RUN_W-1:0] STUCK_LIMIT_RST = 8'd8;
   localparam logic [RAW_W-1:0] SUBSTITUTE_RST  = 16'hFFFF;

   typedef struct packed {
      logic [RAW_W-1:0] raw_0;
      logic [RAW_W-1:0] raw_1;
   } req_type;

   typedef struct packed {
      logic [RAW_W-1:0]   value_0;
      logic [RAW_W-1:0]   value_1;
      logic               range_flag_0;
      logic               stuck_flag_0;
      logic               range_flag_1;
      logic               stuck_flag_1;
      logic               unstable;
      logic [COUNT_W-1:0] range_rejects_0;
      logic [COUNT_W-1:0] stuck_rejects_0;
      logic [COUNT_W-1:0] range_rejects_1;
      logic [COUNT_W-1:0] stuck_rejects_1;
   } rsp_type;

   // per-lane limits handed from the register file to a lane
   typedef struct packed {
      logic [RAW_W-1:0] lo;
      logic [RAW_W-1:0] hi;
      logic [RUN_W-1:0] stuck_limit;
      logic [RAW_W-1:0] substitute;
   } lane_cfg_type;

   // what one lane found for the current tick
   typedef struct packed {
      logic [RAW_W-1:0]   value;
      logic               range_flag;
      logic               stuck_flag;
      logic [COUNT_W-1:0] range_rejects;
      logic [COUNT_W-1:0] stuck_rejects;
   } lane_result_type;

endpackage

@@ hw/rtl/srsv_lane.sv @@
// One sensor lane: run-length tracking, range and stuck checks, reject counters.
// Depends on srsv_pkg.
module srsv_lane (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [srsv_pkg::RAW_W-1:0]  raw,
   input  srsv_pkg::lane_cfg_type      cfg,
   output srsv_pkg::lane_result_type   result
);

   logic [srsv_pkg::RAW_W-1:0]   prev_ff, prev_in;
   logic [srsv_pkg::RUN_W-1:0]   run_ff, run_in;
   logic                         seen_ff, seen_in;
   logic [srsv_pkg::COUNT_W-1:0] rrej_ff, rrej_in;
   logic [srsv_pkg::COUNT_W-1:0] srej_ff, srej_in;
   logic                         range_flag;
   logic                         stuck_flag;
   logic [srsv_pkg::RUN_W-1:0]   run_next;

   always_comb begin
      // restart the run on the first reading or on any change
      if (seen_ff && (raw == prev_ff)) begin
         run_next = (run_ff < srsv_pkg::RUN_MAX) ? run_ff + 1'b1 : run_ff;
      end else begin
         run_next = {{(srsv_pkg::RUN_W-1){1'b0}}, 1'b1};
      end
      range_flag = (raw < cfg.lo) || (raw > cfg.hi);
      stuck_flag = (run_next >= cfg.stuck_limit);

      result.range_flag    = range_flag;
      result.stuck_flag    = stuck_flag;
      result.range_rejects = range_flag ? rrej_ff + 1'b1 : rrej_ff;
      result.stuck_rejects = stuck_flag ? srej_ff + 1'b1 : srej_ff;
      result.value         = (range_flag || stuck_flag) ? cfg.substitute : raw;

      prev_in = prev_ff;
      run_in  = run_ff;
      seen_in = seen_ff;
      rrej_in = rrej_ff;
      srej_in = srej_ff;
      if (accept) begin
         prev_in = raw;
         run_in  = run_next;
         seen_in = 1'b1;
         rrej_in = result.range_rejects;
         srej_in = result.stuck_rejects;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         run_ff  <= '0;
         seen_ff <= 1'b0;
         rrej_ff <= '0;
         srej_ff <= '0;
      end else begin
         prev_ff <= prev_in;
         run_ff  <= run_in;
         seen_ff <= seen_in;
         rrej_ff <= rrej_in;
         srej_ff <= srej_in;
      end
   end

endmodule

@@ hw/rtl/srsv_merge.sv @@
// Merging stage: combines lane results into one result item and buffers it
// in a two-entry output queue. Depends on srsv_pkg.
module srsv_merge (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  srsv_pkg::lane_result_type  lane_res [srsv_pkg::LANE_SLOTS],
   output logic                       full,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output srsv_pkg::rsp_type          rsp_data
);

   srsv_pkg::rsp_type merged;
   srsv_pkg::rsp_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              pop;

   always_comb begin
      merged.value_0         = lane_res[0].value;
      merged.value_1         = lane_res[1].value;
      merged.range_flag_0    = lane_res[0].range_flag;
      merged.stuck_flag_0    = lane_res[0].stuck_flag;
      merged.range_flag_1    = lane_res[1].range_flag;
      merged.stuck_flag_1    = lane_res[1].stuck_flag;
      merged.unstable        = lane_res[0].range_flag | lane_res[0].stuck_flag |
                               lane_res[1].range_flag | lane_res[1].stuck_flag;
      merged.range_rejects_0 = lane_res[0].range_rejects;
      merged.stuck_rejects_0 = lane_res[0].stuck_rejects;
      merged.range_rejects_1 = lane_res[1].range_rejects;
      merged.stuck_rejects_1 = lane_res[1].stuck_rejects;
   end

   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= merged;
      end
   end

endmodule

@@ hw/rtl/sensor_range_stuck_validator.sv @@
// Sensor range and stuck-value validator, top level.
// A result enters the output queue as its tick is transferred and is offered on rsp_ once earlier
// results have gone. Throughput: one tick per cycle while req_stall is low; the lanes check in
// parallel and a two-entry output queue takes a new tick while up to one result waits on rsp_stall.
// Reset (synchronous): registers return to their defaults, lane history and
// reject counters clear, the output queue empties.
module sensor_range_stuck_validator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  srsv_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output srsv_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [srsv_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [srsv_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [srsv_pkg::RAW_W-1:0] min0_ff, max0_ff, min1_ff, max1_ff, subst_ff;
   logic [srsv_pkg::RUN_W-1:0] limit_ff;
   logic                       accept;
   logic                       full;

   logic [srsv_pkg::RAW_W-1:0] lane_raw [srsv_pkg::LANE_SLOTS];
   srsv_pkg::lane_cfg_type     lane_cfg [srsv_pkg::LANE_SLOTS];
   srsv_pkg::lane_result_type  lane_res [srsv_pkg::LANE_SLOTS];

   assign req_stall = full;
   assign accept    = req_valid && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         min0_ff  <= srsv_pkg::MIN_SENSOR0_RST;
         max0_ff  <= srsv_pkg::MAX_SENSOR0_RST;
         min1_ff  <= srsv_pkg::MIN_SENSOR1_RST;
         max1_ff  <= srsv_pkg::MAX_SENSOR1_RST;
         limit_ff <= srsv_pkg::STUCK_LIMIT_RST;
         subst_ff <= srsv_pkg::SUBSTITUTE_RST;
      end else if (csr_we) begin
         case (csr_index)
            srsv_pkg::CSR_MIN_SENSOR0:      min0_ff  <= csr_wdata;
            srsv_pkg::CSR_MAX_SENSOR0:      max0_ff  <= csr_wdata;
            srsv_pkg::CSR_MIN_SENSOR1:      min1_ff  <= csr_wdata;
            srsv_pkg::CSR_MAX_SENSOR1:      max1_ff  <= csr_wdata;
            srsv_pkg::CSR_STUCK_LIMIT:      limit_ff <= csr_wdata[srsv_pkg::RUN_W-1:0];
            srsv_pkg::CSR_SUBSTITUTE_VALUE: subst_ff <= csr_wdata;
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   always_comb begin
      lane_raw[0]             = req_data.raw_0;
      lane_raw[1]             = req_data.raw_1;
      lane_cfg[0].lo          = min0_ff;
      lane_cfg[0].hi          = max0_ff;
      lane_cfg[0].stuck_limit = limit_ff;
      lane_cfg[0].substitute  = subst_ff;
      lane_cfg[1].lo          = min1_ff;
      lane_cfg[1].hi          = max1_ff;
      lane_cfg[1].stuck_limit = limit_ff;
      lane_cfg[1].substitute  = subst_ff;
   end

   for (genvar g = 0; g < srsv_pkg::LANE_SLOTS; g++) begin : g_lane
      if (g < srsv_pkg::SENSOR_LANES) begin : g_built
         srsv_lane u_lane (
            .clock  (clock),
            .reset  (reset),
            .accept (accept),
            .raw    (lane_raw[g]),
            .cfg    (lane_cfg[g]),
            .result (lane_res[g])
         );
      end else begin : g_absent
         // absent lane reports all zeros
         assign lane_res[g] = '0;
      end
   end

   srsv_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .lane_res  (lane_res),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/srsv_result_checker.sv @@
// Result checker for the sensor range and stuck-value validator.
// Watches the req_, rsp_ and csr_ ports, predicts each tick's result and compares it.
// Depends on srsv_pkg for the payload types, widths and register indexes.
module srsv_result_checker
   import srsv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    ticks_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   // register copies
   logic [RAW_W-1:0]   lane_lo [LANE_SLOTS];
   logic [RAW_W-1:0]   lane_hi [LANE_SLOTS];
   logic [RUN_W-1:0]   stuck_limit;
   logic [RAW_W-1:0]   substitute;

   // lane history and reject totals
   logic [RAW_W-1:0]   last_raw    [LANE_SLOTS];
   logic [RUN_W-1:0]   run_len     [LANE_SLOTS];
   logic               lane_seen   [LANE_SLOTS];
   logic [COUNT_W-1:0] range_total [LANE_SLOTS];
   logic [COUNT_W-1:0] stuck_total [LANE_SLOTS];

   rsp_type expected_ticks [$];

   function automatic rsp_type grade_tick(req_type r);
      rsp_type          o;
      logic [RAW_W-1:0] raw [LANE_SLOTS];
      logic [RAW_W-1:0] val [LANE_SLOTS];
      logic             rng [LANE_SLOTS];
      logic             stk [LANE_SLOTS];
      raw[0] = r.raw_0;
      raw[1] = r.raw_1;
      for (int k = 0; k < LANE_SLOTS; k++) begin
         val[k] = '0;
         rng[k] = 1'b0;
         stk[k] = 1'b0;
         if (k < SENSOR_LANES) begin
            // the run counts every reading, rejected or not, and saturates
            if (lane_seen[k] && raw[k] == last_raw[k]) begin
               if (run_len[k] != RUN_MAX) run_len[k]++;
            end else begin
               run_len[k] = RUN_W'(1);
            end
            last_raw[k]  = raw[k];
            lane_seen[k] = 1'b1;
            rng[k] = (raw[k] < lane_lo[k]) || (raw[k] > lane_hi[k]);
            stk[k] = run_len[k] >= stuck_limit;
            if (rng[k]) range_total[k]++;
            if (stk[k]) stuck_total[k]++;
            val[k] = (rng[k] || stk[k]) ? substitute : raw[k];
         end
      end
      o.value_0         = val[0];
      o.value_1         = val[1];
      o.range_flag_0    = rng[0];
      o.stuck_flag_0    = stk[0];
      o.range_flag_1    = rng[1];
      o.stuck_flag_1    = stk[1];
      o.unstable        = rng[0] | stk[0] | rng[1] | stk[1];
      o.range_rejects_0 = range_total[0];
      o.stuck_rejects_0 = stuck_total[0];
      o.range_rejects_1 = range_total[1];
      o.stuck_rejects_1 = stuck_total[1];
      return o;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void compare_result(rsp_type want, rsp_type got);
      check_field("value_0", want.value_0, got.value_0);
      check_field("value_1", want.value_1, got.value_1);
      check_field("range_flag_0", want.range_flag_0, got.range_flag_0);
      check_field("stuck_flag_0", want.stuck_flag_0, got.stuck_flag_0);
      check_field("range_flag_1", want.range_flag_1, got.range_flag_1);
      check_field("stuck_flag_1", want.stuck_flag_1, got.stuck_flag_1);
      check_field("unstable", want.unstable, got.unstable);
      check_field("range_rejects_0", want.range_rejects_0, got.range_rejects_0);
      check_field("stuck_rejects_0", want.stuck_rejects_0, got.stuck_rejects_0);
      check_field("range_rejects_1", want.range_rejects_1, got.range_rejects_1);
      check_field("stuck_rejects_1", want.stuck_rejects_1, got.stuck_rejects_1);
   endfunction

   function automatic void apply_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_MIN_SENSOR0:      lane_lo[0]  = d[RAW_W-1:0];
         CSR_MAX_SENSOR0:      lane_hi[0]  = d[RAW_W-1:0];
         CSR_MIN_SENSOR1:      lane_lo[1]  = d[RAW_W-1:0];
         CSR_MAX_SENSOR1:      lane_hi[1]  = d[RAW_W-1:0];
         CSR_STUCK_LIMIT:      stuck_limit = d[RUN_W-1:0];
         CSR_SUBSTITUTE_VALUE: substitute  = d[RAW_W-1:0];
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         lane_lo[0]  = MIN_SENSOR0_RST;
         lane_hi[0]  = MAX_SENSOR0_RST;
         lane_lo[1]  = MIN_SENSOR1_RST;
         lane_hi[1]  = MAX_SENSOR1_RST;
         stuck_limit = STUCK_LIMIT_RST;
         substitute  = SUBSTITUTE_RST;
         for (int k = 0; k < LANE_SLOTS; k++) begin
            last_raw[k]    = '0;
            run_len[k]     = '0;
            lane_seen[k]   = 1'b0;
            range_total[k] = '0;
            stuck_total[k] = '0;
         end
         expected_ticks.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_ticks.size() == 0) begin
               $error("result transfer with no tick outstanding");
               mismatch_count++;
            end else begin
               want = expected_ticks.pop_front();
               compare_result(want, rsp_data);
            end
         end
         if (req_valid && !req_stall) expected_ticks.push_back(grade_tick(req_data));
         if (csr_we) apply_write(csr_index, csr_wdata);
      end
      ticks_in_flight = expected_ticks.size();
   end

endmodule

@@ tb/sensor_range_stuck_validator_tb.sv @@
// Testbench top for the sensor range and stuck-value validator.
// Drives ticks and register writes, stalls results at random; srsv_result_checker
// does the prediction and comparison. Depends on srsv_pkg and the RTL.
module sensor_range_stuck_validator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import srsv_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   // indexes past the register file; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatch_count;
   int ticks_in_flight;
   int cycle_count = 0;
   bit steady      = 1'b0;

   // current limits, used to aim readings at the range edges
   logic [RAW_W-1:0] cur_lo [LANE_SLOTS] = '{MIN_SENSOR0_RST, MIN_SENSOR1_RST};
   logic [RAW_W-1:0] cur_hi [LANE_SLOTS] = '{MAX_SENSOR0_RST, MAX_SENSOR1_RST};
   logic [RUN_W-1:0] cur_limit = STUCK_LIMIT_RST;

   sensor_range_stuck_validator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   srsv_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .ticks_in_flight (ticks_in_flight)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && !steady && ($urandom_range(99) < 34);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[sensor_range_stuck_validator] ERROR");
         $finish;
      end
   end

   // offer one tick and hold it until the transfer
   task automatic send_tick(input logic [RAW_W-1:0] a, input logic [RAW_W-1:0] b);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{raw_0: a, raw_1: b};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (ticks_in_flight != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [RAW_W-1:0] lo0, input logic [RAW_W-1:0] hi0,
                                input logic [RAW_W-1:0] lo1, input logic [RAW_W-1:0] hi1,
                                input logic [CSR_DATA_W-1:0] limit_word,
                                input logic [RAW_W-1:0] subst);
      drain();
      write_reg(CSR_MIN_SENSOR0, lo0);
      write_reg(CSR_MAX_SENSOR0, hi0);
      write_reg(CSR_SPARE_LO, CSR_DATA_W'($urandom));
      write_reg(CSR_MIN_SENSOR1, lo1);
      write_reg(CSR_MAX_SENSOR1, hi1);
      write_reg(CSR_STUCK_LIMIT, limit_word);
      write_reg(CSR_SUBSTITUTE_VALUE, subst);
      write_reg(CSR_SPARE_HI, CSR_DATA_W'($urandom));
      @(negedge clock);
      csr_we <= 1'b0;
      cur_lo[0] = lo0;
      cur_hi[0] = hi0;
      cur_lo[1] = lo1;
      cur_hi[1] = hi1;
      cur_limit = limit_word[RUN_W-1:0];
   endtask

   function automatic logic [RAW_W-1:0] pick_reading(int lane);
      case ($urandom_range(5))
         0: return cur_lo[lane] - 16'd1;
         1: return cur_lo[lane];
         2: return cur_hi[lane];
         3: return cur_hi[lane] + 16'd1;
         4: begin
            if (cur_lo[lane] <= cur_hi[lane])
               return cur_lo[lane] + RAW_W'($urandom_range(cur_hi[lane] - cur_lo[lane]));
            return RAW_W'($urandom);
         end
         default: return RAW_W'($urandom);
      endcase
   endfunction

   // runs of repeated readings near the limits, mixed with raw noise
   task automatic random_phase(input int count);
      int               sent;
      int               run;
      logic [RAW_W-1:0] a;
      logic [RAW_W-1:0] b;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 70) begin
            if ($urandom_range(3) == 0 && cur_limit < 40)
               run = cur_limit + $urandom_range(2);
            else
               run = $urandom_range(1, 12);
            a = pick_reading(0);
            b = pick_reading(1);
            repeat (run) begin
               if ($urandom_range(4) == 0) b = pick_reading(1);
               send_tick(a, b);
               sent++;
            end
         end else begin
            send_tick(RAW_W'($urandom), RAW_W'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // range edges at the reset limits
      send_tick(16'h0000, 16'h0000);
      send_tick(16'hFFFF, 16'hFFFF);
      send_tick(MIN_SENSOR0_RST, MIN_SENSOR1_RST);
      send_tick(MAX_SENSOR0_RST, MAX_SENSOR1_RST);
      send_tick(MIN_SENSOR0_RST - 16'd1, MIN_SENSOR1_RST - 16'd1);
      send_tick(MAX_SENSOR0_RST + 16'd1, MAX_SENSOR1_RST + 16'd1);
      // equal readings until the stuck limit, then break lane zero's run
      repeat (9) send_tick(16'd1000, 16'd500);
      send_tick(16'd1001, 16'd500);
      // stuck limit zero via a wide write: every reading is stuck
      apply_setting(MIN_SENSOR0_RST, MAX_SENSOR0_RST, MIN_SENSOR1_RST, MAX_SENSOR1_RST,
                    16'hFF00, 16'h1234);
      send_tick(16'd1000, 16'd500);
      send_tick(16'd1001, 16'd501);
      send_tick(16'd1001, 16'd501);

      // widest limits, longest stuck limit; drive the run count into saturation
      apply_setting(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h00FF, 16'h0000);
      repeat (260) send_tick(16'h5A5A, 16'h0F0F);
      random_phase(40);

      // min above max on both lanes, every reading stuck at once
      apply_setting(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'hA5A5);
      random_phase(30);

      for (int p = 0; p < 4; p++) begin
         logic [RAW_W-1:0] lo0;
         logic [RAW_W-1:0] lo1;
         lo0 = RAW_W'($urandom_range(0, 40000));
         lo1 = RAW_W'($urandom_range(0, 40000));
         apply_setting(lo0, lo0 + RAW_W'($urandom_range(0, 20000)),
                       lo1, lo1 + RAW_W'($urandom_range(0, 20000)),
                       {8'($urandom), 8'($urandom_range(2, 12))}, RAW_W'($urandom));
         steady = (p == 1);
         random_phase(p == 1 ? 50 : 35);
         steady = 1'b0;
      end

      drain();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0)
         $display("[sensor_range_stuck_validator] OK");
      else
         $display("[sensor_range_stuck_validator] ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/srsv_pkg.sv
hw/rtl/srsv_lane.sv
hw/rtl/srsv_merge.sv
hw/rtl/sensor_range_stuck_validator.sv
tb/srsv_result_checker.sv
tb/sensor_range_stuck_validator_tb.sv
